// ===== rtl/gwwl_pkg.sv =====
package gwwl_pkg;

  localparam logic [15:0] CODE_TAB   = 16'd9;
  localparam logic [15:0] CODE_SPACE = 16'd32;

  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_TAB_WIDTH  = 1'b1;

  localparam logic [15:0] LINE_WIDTH_RST = 16'd640;
  localparam logic [11:0] TAB_WIDTH_RST  = 12'd32;

  localparam int RUN_W = 17;

  typedef struct packed {
    logic [15:0] char_code;
    logic [9:0]  glyph_width;
    logic        para_start;
  } in_item_t;

  typedef struct packed {
    logic [11:0] advance;
    logic        line_break;
    logic [15:0] break_index;
  } out_item_t;

endpackage

// ===== rtl/greedy_word_wrap_line_breaker_top.sv =====
// Greedy word-wrap line breaker. Characters of one paragraph come in one item
// at a time and each gives exactly one result: the advance of the character
// (a tab is expanded to the next tab stop) and, when the line overflows, the
// index of the first character of the new line. An ordinary character stalls
// the input while it passes through S_SUM and S_DONE, and its result is written
// to the output register as it leaves S_DONE; a tab passes through S_MOD first,
// since its advance needs the running width modulo the tab width, worked out by
// one shared restoring subtractor at one quotient bit per cycle over the 17-bit
// width. A finished result waits in the output register while the next item is
// accepted and worked on; while the receiver stalls a result that is still held
// there, the next result waits and the input stays stalled. A tab width of 0
// acts as 1. Configuration writes are taken at any cycle and should only be
// issued while the block is idle.
module greedy_word_wrap_line_breaker_top #(
  parameter int unsigned MAX_PARA_CHARS = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gwwl_pkg::in_item_t in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output gwwl_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOD  = 4'b0010,
    S_SUM  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  localparam int RW = gwwl_pkg::RUN_W;

  state_t state_r, state_nxt;

  logic [15:0]   line_width_r;
  logic [11:0]   tab_width_r;

  logic [RW-1:0] run_width_r;
  logic          blank_seen_r;
  logic [15:0]   blank_index_r;
  logic [RW-1:0] wtb_r;
  logic [15:0]   char_index_r;

  gwwl_pkg::in_item_t item_r;
  logic [11:0]   rem_r;
  logic [4:0]    div_cnt_r;
  logic [11:0]   cw_r;
  logic [RW-1:0] sum_r;

  logic               out_valid_r;
  gwwl_pkg::out_item_t out_item_r;

  logic [11:0]   tw;
  logic          is_tab, is_blank;
  logic [12:0]   trial;
  logic          trial_ge;
  logic [11:0]   rem_nxt;
  logic          accept, out_free;

  assign tw       = (tab_width_r == 12'd0) ? 12'd1 : tab_width_r;
  assign is_tab   = (item_r.char_code == gwwl_pkg::CODE_TAB);
  assign is_blank = is_tab || (item_r.char_code == gwwl_pkg::CODE_SPACE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // one restoring step of run_width mod tw
  assign trial    = {rem_r, run_width_r[div_cnt_r]};
  assign trial_ge = (trial >= {1'b0, tw});
  assign rem_nxt  = trial_ge ? 12'(trial - {1'b0, tw}) : trial[11:0];

  // break decision on the registered sum
  logic [RW-1:0] wtb_new;
  logic          bs_new;
  logic          brk;
  logic [15:0]   brk_idx;
  logic [RW-1:0] x_new;
  logic          blank_seen_nxt;
  logic [16:0]   idx_inc;
  logic [15:0]   idx_nxt;

  always_comb begin
    wtb_new        = is_blank ? sum_r : wtb_r;
    bs_new         = is_blank || blank_seen_r;
    brk            = 1'b0;
    brk_idx        = 16'd0;
    x_new          = sum_r;
    blank_seen_nxt = bs_new;
    if (sum_r > {1'b0, line_width_r}) begin
      brk = 1'b1;
      if (bs_new) begin
        brk_idx        = is_blank ? 16'(char_index_r + 16'd1) : 16'(blank_index_r + 16'd1);
        blank_seen_nxt = 1'b0;
        x_new          = RW'(sum_r - wtb_new);
      end else begin
        brk_idx = char_index_r;
        x_new   = {5'd0, cw_r};
      end
    end
    idx_inc = {1'b0, char_index_r} + 17'd1;
    idx_nxt = ({15'd0, idx_inc} >= MAX_PARA_CHARS[31:0]) ? 16'd0 : idx_inc[15:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = (in_item.char_code == gwwl_pkg::CODE_TAB) ? S_MOD : S_SUM;
      S_MOD:  if (div_cnt_r == 5'd0) state_nxt = S_SUM;
      S_SUM:  state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      line_width_r  <= gwwl_pkg::LINE_WIDTH_RST;
      tab_width_r   <= gwwl_pkg::TAB_WIDTH_RST;
      run_width_r   <= '0;
      blank_seen_r  <= 1'b0;
      blank_index_r <= '0;
      wtb_r         <= '0;
      char_index_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          gwwl_pkg::REG_LINE_WIDTH: line_width_r <= cfg_wdata;
          gwwl_pkg::REG_TAB_WIDTH:  tab_width_r  <= cfg_wdata[11:0];
          default: ;
        endcase
      end
      // paragraph start clears state before the item is worked on
      if (accept && in_item.para_start) begin
        run_width_r   <= '0;
        blank_seen_r  <= 1'b0;
        blank_index_r <= '0;
        wtb_r         <= '0;
        char_index_r  <= '0;
      end
      if (state_r == S_DONE && out_free) begin
        run_width_r  <= x_new;
        blank_seen_r <= blank_seen_nxt;
        wtb_r        <= wtb_new;
        char_index_r <= idx_nxt;
        if (is_blank) blank_index_r <= char_index_r;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r    <= in_item;
      rem_r     <= '0;
      div_cnt_r <= 5'(RW - 1);
    end
    if (state_r == S_MOD) begin
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r - 5'd1;
    end
    if (state_r == S_SUM) begin
      cw_r  <= is_tab ? 12'(tw - rem_r) : {2'd0, item_r.glyph_width};
      sum_r <= RW'(run_width_r + (is_tab ? RW'(tw - rem_r) : RW'(item_r.glyph_width)));
    end
    if (state_r == S_DONE && out_free) begin
      out_item_r.advance     <= cw_r;
      out_item_r.line_break  <= brk;
      out_item_r.break_index <= brk_idx;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== sim/gwwl_checker.sv =====
module gwwl_checker #(
  parameter int unsigned MAX_PARA_CHARS = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  gwwl_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  gwwl_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata,
  output int                  fail_count,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] line_width_q;
  logic [11:0] tab_width_q;

  // paragraph layout state
  logic [16:0] run_width;
  logic        blank_seen;
  logic [15:0] blank_index;
  logic [16:0] width_thru_blank;
  logic [15:0] char_index;

  gwwl_pkg::out_item_t expected_layout[$];
  gwwl_pkg::out_item_t predicted;
  gwwl_pkg::out_item_t oldest;
  int        errors = 0;

  task automatic clear_paragraph();
    run_width = '0;
    blank_seen = 1'b0;
    blank_index = '0;
    width_thru_blank = '0;
    char_index = '0;
  endtask

  // Lay out one character: advance, and where the next line starts on overflow.
  task automatic wrap_char(input gwwl_pkg::in_item_t c, output gwwl_pkg::out_item_t r);
    logic [11:0] tw;
    logic [16:0] x;
    logic [16:0] adv;
    logic [15:0] idx;
    tw = (tab_width_q == '0) ? 12'd1 : tab_width_q;
    if (c.para_start)
      clear_paragraph();
    idx = char_index;
    x = run_width;
    if (c.char_code == gwwl_pkg::CODE_TAB)
      adv = {5'b0, tw} - (x % {5'b0, tw});
    else
      adv = {7'b0, c.glyph_width};
    if (c.char_code == gwwl_pkg::CODE_SPACE || c.char_code == gwwl_pkg::CODE_TAB) begin
      blank_seen = 1'b1;
      blank_index = idx;
      width_thru_blank = x + adv;
    end
    x = x + adv;
    r = '0;
    if (x > {1'b0, line_width_q}) begin
      r.line_break = 1'b1;
      if (blank_seen) begin
        r.break_index = blank_index + 16'd1;
        blank_seen = 1'b0;
        x = x - width_thru_blank;
      end else begin
        r.break_index = idx;
        x = adv;
      end
    end
    run_width = x;
    char_index = (32'(idx) + 1 >= MAX_PARA_CHARS) ? 16'd0 : idx + 16'd1;
    r.advance = adv[11:0];
  endtask

  task automatic report(input string field, input int exp_val, input int act_val);
    errors++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, field, exp_val,
             act_val);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      line_width_q = gwwl_pkg::LINE_WIDTH_RST;
      tab_width_q = gwwl_pkg::TAB_WIDTH_RST;
      clear_paragraph();
      expected_layout.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gwwl_pkg::REG_LINE_WIDTH: line_width_q = cfg_wdata;
          gwwl_pkg::REG_TAB_WIDTH:  tab_width_q = cfg_wdata[11:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_layout.size() == 0) begin
          report("unexpected item, break_index", -1, out_item.break_index);
        end else begin
          oldest = expected_layout.pop_front();
          if (out_item.advance !== oldest.advance)
            report("advance", oldest.advance, out_item.advance);
          if (out_item.line_break !== oldest.line_break)
            report("line_break", oldest.line_break, out_item.line_break);
          if (out_item.break_index !== oldest.break_index)
            report("break_index", oldest.break_index, out_item.break_index);
        end
      end
      if (in_valid && !in_stall) begin
        wrap_char(in_item, predicted);
        expected_layout.push_back(predicted);
      end
    end
    outstanding <= expected_layout.size();
    fail_count <= errors;
  end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES = 300;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  gwwl_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  gwwl_pkg::out_item_t out_item;
  logic                cfg_we = 1'b0;
  logic                cfg_index = gwwl_pkg::REG_LINE_WIDTH;
  logic [15:0]         cfg_wdata = '0;

  int fail_count;
  int outstanding;

  // receiver and sender pacing controls
  bit rx_free = 1'b1;
  bit hold_req = 1'b0;
  bit tx_bursty = 1'b0;
  int burst_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  greedy_word_wrap_line_breaker_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  gwwl_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // Receiver: free-running, random stall segments, or one long hold-off.
  initial begin
    int seg;
    int pct;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end else if (rx_free) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        seg = $urandom_range(1, 40);
        case ($urandom_range(3))
          0: pct = 0;
          1: pct = 20;
          2: pct = 50;
          default: pct = 85;
        endcase
        repeat (seg) begin
          out_stall <= ($urandom_range(99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_char(input logic [15:0] code, input logic [9:0] glyph,
                           input logic start);
    in_item <= '{char_code: code, glyph_width: glyph, para_start: start};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic offer_char(input logic [15:0] code, input logic [9:0] glyph,
                            input logic start);
    if (tx_bursty && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(100, 200)
                                            : $urandom_range(1, 20);
    end
    if (burst_left > 0)
      burst_left--;
    send_char(code, glyph, start);
  endtask

  // Block is idle once every result is back and the slowest item has drained.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_layout(input logic [15:0] lw, input logic [11:0] tw);
    wait_idle();
    write_reg(gwwl_pkg::REG_LINE_WIDTH, lw);
    write_reg(gwwl_pkg::REG_TAB_WIDTH, {4'b0, tw});
  endtask

  function automatic logic [15:0] pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 14)
      return gwwl_pkg::CODE_SPACE;
    else if (r < 19)
      return gwwl_pkg::CODE_TAB;
    else if (r < 23)
      return 16'($urandom());
    else
      return 16'($urandom_range(33, 126));
  endfunction

  function automatic logic [9:0] pick_glyph(input int gmax);
    if ($urandom_range(15) == 0)
      return 10'($urandom_range(1023));
    return 10'($urandom_range(gmax));
  endfunction

  // Random paragraphs under one line/tab setting, paced by bursts and stalls.
  task automatic random_phase(input logic [15:0] lw, input logic [11:0] tw,
                              input int n_chars, input int gmax, input bit hold);
    int sent;
    int plen;
    set_layout(lw, tw);
    rx_free = 1'b0;
    tx_bursty = 1'b1;
    burst_left = 0;
    if (hold)
      hold_req = 1'b1;
    sent = 0;
    while (sent < n_chars) begin
      plen = $urandom_range(1, 90);
      for (int j = 0; j < plen && sent < n_chars; j++) begin
        offer_char(pick_code(), pick_glyph(gmax),
                   (j == 0) || ($urandom_range(99) == 0));
        sent++;
      end
    end
    rx_free = 1'b1;
    tx_bursty = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: narrow line, small tab stops
    set_layout(16'd100, 12'd8);
    send_char(16'h0057, 10'd1023, 1'b1); // oversized first char breaks at itself
    send_char(16'h0061, 10'd10, 1'b0);
    send_char(gwwl_pkg::CODE_TAB, 10'd0, 1'b0);
    send_char(16'h0062, 10'd30, 1'b0);
    send_char(16'h0063, 10'd30, 1'b0);
    send_char(gwwl_pkg::CODE_SPACE, 10'd5, 1'b0);
    send_char(16'h0064, 10'd30, 1'b0);  // breaks after the space
    send_char(gwwl_pkg::CODE_SPACE, 10'd100, 1'b0);
    send_char(16'h0065, 10'd10, 1'b0);
    send_char(gwwl_pkg::CODE_SPACE, 10'd5, 1'b0);
    send_char(16'h0066, 10'd1023, 1'b0); // still too wide after blank break
    send_char(16'h0067, 10'd1, 1'b0);
    send_char(16'hFFFF, 10'd1023, 1'b0);
    send_char(16'h0000, 10'd0, 1'b0);
    send_char(gwwl_pkg::CODE_TAB, 10'd1023, 1'b1); // tab at line start
    send_char(gwwl_pkg::CODE_TAB, 10'd0, 1'b0);

    // zero line width and zero tab width
    set_layout(16'd0, 12'd0);
    send_char(gwwl_pkg::CODE_TAB, 10'd0, 1'b1);
    send_char(16'h0041, 10'd0, 1'b0);
    send_char(16'h0042, 10'd1, 1'b0);
    send_char(gwwl_pkg::CODE_SPACE, 10'd0, 1'b0);

    // widest settings
    set_layout(16'hFFFF, 12'hFFF);
    send_char(gwwl_pkg::CODE_TAB, 10'd0, 1'b1);
    send_char(16'h0043, 10'd1023, 1'b0);
    send_char(gwwl_pkg::CODE_TAB, 10'd0, 1'b0);

    random_phase(gwwl_pkg::LINE_WIDTH_RST, gwwl_pkg::TAB_WIDTH_RST, 150, 40, 1'b1);
    random_phase(16'd120, 12'd8, 150, 30, 1'b0);
    random_phase(16'hFFFF, 12'hFFF, 150, 1023, 1'b0);
    random_phase(16'd0, 12'd0, 150, 2, 1'b0);
    random_phase(16'd1, 12'd1, 150, 2, 1'b0);
    random_phase(16'($urandom_range(1, 3000)), 12'($urandom()), 150, 200, 1'b0);
    random_phase(16'($urandom()), 12'($urandom()), 150, 1023, 1'b0);

    wait_idle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gwwl_pkg.sv
rtl/greedy_word_wrap_line_breaker_top.sv
sim/gwwl_checker.sv
sim/tb_top.sv
